// File: sv/ipvl_pkg.sv
// shared types, codes and constants for the interval paint label counter
`timescale 1ns / 1ps
package ipvl_pkg;

	localparam int COORD_W          = 32;
	localparam int PORT_LABEL_W     = 8;
	localparam int COUNT_W          = 8;
	localparam int DEF_MAX_SEGMENTS = 256;
	localparam int DEF_LABEL_BITS   = 8;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MIN      = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX      = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t WALL_LEFT_RST  = coord_t'(0);
	localparam coord_t WALL_RIGHT_RST = coord_t'(1024);

	localparam logic CMD_PAINT      = 1'b0;
	localparam logic CMD_COUNT      = 1'b1;
	localparam logic REG_WALL_LEFT  = 1'b0;
	localparam logic REG_WALL_RIGHT = 1'b1;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MERGE,
		OP_SPLIT_LO,
		OP_SPLIT_HI,
		OP_RELABEL
	} seg_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_PAINT,
		S_COUNT
	} state_t;

	typedef struct packed {
		seg_op_t op;
		logic    merge_del;
		coord_t  lo;
		coord_t  hi;
		coord_t  lo_m1;
		coord_t  hi_p1;
		coord_t  wall_lo;
		coord_t  wall_hi;
	} bcast_t;

	typedef struct packed {
		logic second;
		logic second_in;
		logic split_lo;
		logic split_hi;
		logic single;
		logic pair;
		logic hit;
	} cell_flags_t;

endpackage

// File: sv/ipvl_cmd_if.sv
// command channel interface
`timescale 1ns / 1ps
interface ipvl_cmd_if import ipvl_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic                    command;
	coord_t                  paint_start;
	coord_t                  paint_end;
	logic [PORT_LABEL_W-1:0] paint_label;

	modport source (output valid, command, paint_start, paint_end, paint_label, input ready);
	modport sink (input valid, command, paint_start, paint_end, paint_label, output ready);
endinterface

// File: sv/ipvl_res_if.sv
// result channel interface
`timescale 1ns / 1ps
interface ipvl_res_if import ipvl_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] visible_count;
	logic               overflowed;

	modport source (output valid, visible_count, overflowed, input ready);
	modport sink (input valid, visible_count, overflowed, output ready);
endinterface

// File: sv/ipvl_cfg_if.sv
// configuration write channel interface
`timescale 1ns / 1ps
interface ipvl_cfg_if import ipvl_pkg::*; ;
	logic   valid;
	logic   ready;
	logic   index;
	coord_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/ipvl_cell.sv
// one segment cell of the chain
`timescale 1ns / 1ps
module ipvl_cell import ipvl_pkg::*; #(
	parameter int LABEL_BITS = DEF_LABEL_BITS,
	parameter bit HEAD       = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcast_t                bc,
	input  logic [LABEL_BITS-1:0] lab,
	input  logic [LABEL_BITS-1:0] sweep_label,
	input  logic                  p_valid,
	input  coord_t                p_start,
	input  coord_t                p_stop,
	input  logic [LABEL_BITS-1:0] p_label,
	input  logic                  p_cov,
	input  logic                  p_first,
	input  logic                  n_valid,
	input  coord_t                n_start,
	input  coord_t                n_stop,
	input  logic [LABEL_BITS-1:0] n_label,
	input  logic                  n_cov,
	output logic                  valid,
	output coord_t                start,
	output coord_t                stop,
	output logic [LABEL_BITS-1:0] label,
	output logic                  cov,
	output logic                  first,
	output cell_flags_t           flags
);

	logic                  valid_q, valid_d;
	coord_t                start_q, start_d, stop_q, stop_d;
	logic [LABEL_BITS-1:0] label_q, label_d;
	logic                  second, last;

	assign cov    = valid_q && (stop_q >= bc.lo) && (start_q <= bc.hi);
	assign first  = cov && !p_cov;
	assign second = cov && p_cov && p_first;
	assign last   = cov && !n_cov;

	assign flags.second    = second;
	assign flags.second_in = second && (stop_q <= bc.hi);
	assign flags.split_lo  = first && (start_q < bc.lo);
	assign flags.split_hi  = cov && (stop_q > bc.hi);
	assign flags.single    = first && last;
	assign flags.pair      = second && last;
	assign flags.hit       = valid_q && (label_q == sweep_label) && (label_q != '0)
		&& (stop_q >= bc.wall_lo) && (start_q < bc.wall_hi);

	assign valid = valid_q;
	assign start = start_q;
	assign stop  = stop_q;
	assign label = label_q;

	always_comb begin
		valid_d = valid_q;
		start_d = start_q;
		stop_d  = stop_q;
		label_d = label_q;
		unique case (bc.op)
			OP_MERGE: begin
				if (first && n_cov) begin
					stop_d = bc.merge_del ? n_stop : bc.hi;
				end else if (bc.merge_del) begin
					if (!valid_q || start_q > bc.lo) begin
						valid_d = n_valid;
						start_d = n_start;
						stop_d  = n_stop;
						label_d = n_label;
					end
				end else if (second) begin
					start_d = bc.hi_p1;
				end
			end
			OP_SPLIT_LO: begin
				if (cov) begin
					stop_d = bc.lo_m1;
				end else if (!valid_q || start_q > bc.lo) begin
					valid_d = p_valid;
					start_d = p_cov ? bc.lo : p_start;
					stop_d  = p_stop;
					label_d = p_label;
				end
			end
			OP_SPLIT_HI: begin
				if (cov) begin
					stop_d  = bc.hi;
					label_d = lab;
				end else if (!valid_q || start_q > bc.hi) begin
					valid_d = p_valid;
					start_d = p_cov ? bc.hi_p1 : p_start;
					stop_d  = p_stop;
					label_d = p_label;
				end
			end
			OP_RELABEL: begin
				if (cov) begin
					label_d = lab;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= HEAD;
			start_q <= COORD_MIN;
			stop_q  <= COORD_MAX;
			label_q <= '0;
		end else begin
			valid_q <= valid_d;
			start_q <= start_d;
			stop_q  <= stop_d;
			label_q <= label_d;
		end
	end

endmodule

// File: sv/ipvl_row.sv
// row of segment cells with neighbour links and flag reduction
`timescale 1ns / 1ps
module ipvl_row import ipvl_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int LABEL_BITS   = DEF_LABEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcast_t                bc,
	input  logic [LABEL_BITS-1:0] lab,
	input  logic [LABEL_BITS-1:0] sweep_label,
	output cell_flags_t           any
);

	logic                  valid_a [MAX_SEGMENTS];
	coord_t                start_a [MAX_SEGMENTS];
	coord_t                stop_a  [MAX_SEGMENTS];
	logic [LABEL_BITS-1:0] label_a [MAX_SEGMENTS];
	logic                  cov_a   [MAX_SEGMENTS];
	logic                  first_a [MAX_SEGMENTS];
	cell_flags_t           flags_a [MAX_SEGMENTS];

	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		logic                  pv, pc, pf, nv, nc;
		coord_t                ps, pe, ns, ne;
		logic [LABEL_BITS-1:0] pl, nl;

		if (i == 0) begin : g_head
			assign pv = 1'b0;
			assign ps = COORD_MIN;
			assign pe = COORD_MIN;
			assign pl = '0;
			assign pc = 1'b0;
			assign pf = 1'b0;
		end else begin : g_link_p
			assign pv = valid_a[i-1];
			assign ps = start_a[i-1];
			assign pe = stop_a[i-1];
			assign pl = label_a[i-1];
			assign pc = cov_a[i-1];
			assign pf = first_a[i-1];
		end

		if (i == MAX_SEGMENTS - 1) begin : g_tail
			assign nv = 1'b0;
			assign ns = COORD_MAX;
			assign ne = COORD_MAX;
			assign nl = '0;
			assign nc = 1'b0;
		end else begin : g_link_n
			assign nv = valid_a[i+1];
			assign ns = start_a[i+1];
			assign ne = stop_a[i+1];
			assign nl = label_a[i+1];
			assign nc = cov_a[i+1];
		end

		ipvl_cell #(
			.LABEL_BITS (LABEL_BITS),
			.HEAD       (i == 0)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.bc          (bc),
			.lab         (lab),
			.sweep_label (sweep_label),
			.p_valid     (pv),
			.p_start     (ps),
			.p_stop      (pe),
			.p_label     (pl),
			.p_cov       (pc),
			.p_first     (pf),
			.n_valid     (nv),
			.n_start     (ns),
			.n_stop      (ne),
			.n_label     (nl),
			.n_cov       (nc),
			.valid       (valid_a[i]),
			.start       (start_a[i]),
			.stop        (stop_a[i]),
			.label       (label_a[i]),
			.cov         (cov_a[i]),
			.first       (first_a[i]),
			.flags       (flags_a[i])
		);
	end

	always_comb begin
		any = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			any = any | flags_a[i];
		end
	end

endmodule

// File: sv/interval_paint_visible_label_count_core.sv
// top level: command sequencer, configuration registers and result register
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    command, paint_start, paint_end, paint_label
//  res      out  valid/ready    visible_count, overflowed
//  cfg      in   valid/ready    index, data
//
// paint with empty clipped span: dropped in idle; else eval drops it on overflow,
// else paint merges once per covered segment past the first, splits once per edge
// split, then relabels; count sweeps labels 1 to all ones, one label per cycle,
// the last waiting on a full res register; reset leaves one blank segment over the
// whole line, no clearing pass; cmd is taken only while idle
`timescale 1ns / 1ps
module interval_paint_visible_label_count_core import ipvl_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
	parameter int LABEL_BITS   = DEF_LABEL_BITS
) (
	input logic        clk,
	input logic        arst_n,
	ipvl_cmd_if.sink   cmd,
	ipvl_res_if.source res,
	ipvl_cfg_if.sink   cfg
);

	localparam int TOT_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [TOT_W:0] CAP  = (TOT_W+1)'(MAX_SEGMENTS);
	localparam logic [TOT_W:0] CAP1 = (TOT_W+1)'(MAX_SEGMENTS + 1);

	state_t                state_q, state_d;
	coord_t                wall_left_q, wall_right_q;
	coord_t                lo_q, hi_q, lo_m1_q, hi_p1_q;
	logic [LABEL_BITS-1:0] lab_q, sweep_q;
	logic [TOT_W-1:0]      total_q;
	logic                  ovf_q;
	logic [COUNT_W-1:0]    cnt_q, cnt_d;
	logic                  out_valid_q, out_ovf_q;
	logic [COUNT_W-1:0]    out_count_q;

	bcast_t      bc;
	cell_flags_t any;
	coord_t      s_clip, e_clip;
	logic        nonempty, wall_ok, sweep_last, step, ovf_hit;
	logic [TOT_W:0] grow;

	assign s_clip   = (cmd.paint_start < wall_left_q) ? wall_left_q : cmd.paint_start;
	assign e_clip   = (cmd.paint_end > wall_right_q) ? wall_right_q : cmd.paint_end;
	assign nonempty = s_clip < e_clip;
	assign wall_ok  = wall_left_q < wall_right_q;

	assign sweep_last = (sweep_q == '1);
	assign step       = !(sweep_last && out_valid_q && !res.ready);
	assign cnt_d      = cnt_q + COUNT_W'(any.hit && wall_ok && (cnt_q != '1));

	assign grow    = {1'b0, total_q} + (TOT_W+1)'(any.split_lo) + (TOT_W+1)'(any.split_hi);
	assign ovf_hit = (any.single && grow > CAP) || (any.pair && grow > CAP1);

	always_comb begin
		state_d      = state_q;
		bc.op        = OP_HOLD;
		bc.merge_del = any.second_in;
		bc.lo        = lo_q;
		bc.hi        = hi_q;
		bc.lo_m1     = lo_m1_q;
		bc.hi_p1     = hi_p1_q;
		bc.wall_lo   = wall_left_q;
		bc.wall_hi   = wall_right_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					if (cmd.command == CMD_COUNT) begin
						state_d = S_COUNT;
					end else if (nonempty) begin
						state_d = S_EVAL;
					end
				end
			end
			S_EVAL: begin
				state_d = ovf_hit ? S_IDLE : S_PAINT;
			end
			S_PAINT: begin
				priority if (any.second) begin
					bc.op = OP_MERGE;
				end else if (any.split_lo) begin
					bc.op = OP_SPLIT_LO;
				end else if (any.split_hi) begin
					bc.op = OP_SPLIT_HI;
				end else begin
					bc.op   = OP_RELABEL;
					state_d = S_IDLE;
				end
			end
			S_COUNT: begin
				if (sweep_last && step) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	ipvl_row #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.LABEL_BITS   (LABEL_BITS)
	) u_row (
		.clk         (clk),
		.arst_n      (arst_n),
		.bc          (bc),
		.lab         (lab_q),
		.sweep_label (sweep_q),
		.any         (any)
	);

	assign cmd.ready         = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign res.valid         = out_valid_q;
	assign res.visible_count = out_count_q;
	assign res.overflowed    = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wall_left_q  <= WALL_LEFT_RST;
			wall_right_q <= WALL_RIGHT_RST;
			total_q      <= TOT_W'(1);
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				if (cfg.index == REG_WALL_LEFT) begin
					wall_left_q <= cfg.data;
				end else begin
					wall_right_q <= cfg.data;
				end
			end
			if (state_q == S_EVAL && ovf_hit) begin
				ovf_q <= 1'b1;
			end
			if (bc.op == OP_MERGE && any.second_in) begin
				total_q <= total_q - TOT_W'(1);
			end else if (bc.op == OP_SPLIT_LO || bc.op == OP_SPLIT_HI) begin
				total_q <= total_q + TOT_W'(1);
			end
			if (state_q == S_COUNT && sweep_last && step) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			lo_q    <= s_clip;
			hi_q    <= e_clip - coord_t'(1);
			lo_m1_q <= s_clip - coord_t'(1);
			hi_p1_q <= e_clip;
			lab_q   <= LABEL_BITS'(cmd.paint_label);
			sweep_q <= LABEL_BITS'(1);
			cnt_q   <= '0;
		end else if (state_q == S_COUNT && step) begin
			sweep_q <= sweep_q + LABEL_BITS'(1);
			cnt_q   <= cnt_d;
			if (sweep_last) begin
				out_count_q <= cnt_d;
				out_ovf_q   <= ovf_q;
			end
		end
	end

endmodule

// File: sv/ipvl_checker.sv
// port-level checks for the interval paint label counter, bound to the top level
`timescale 1ns / 1ps
module ipvl_checker import ipvl_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input logic               cmd_command,
	input logic               res_valid,
	input logic               res_ready,
	input logic [COUNT_W-1:0] res_count,
	input logic               res_overflowed
);

	logic seen_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ovf_q <= 1'b0;
		end else if (res_valid && res_ready && res_overflowed) begin
			seen_ovf_q <= 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_count))
		else $error("result changed while stalled");

	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_command == CMD_COUNT |=> !cmd_ready)
		else $error("command taken during a count sweep");

	a_paint_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_command == CMD_PAINT |=> !$rose(res_valid))
		else $error("paint transaction produced a result");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_ovf_q |-> res_overflowed)
		else $error("overflow flag cleared");

endmodule

bind interval_paint_visible_label_count_core ipvl_checker u_ipvl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_command    (cmd.command),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_count      (res.visible_count),
	.res_overflowed (res.overflowed)
);
